// ----- sv/elu_pkg.sv -----
`timescale 1ns / 1ps

package elu_pkg;

  // Default sample format: signed Q4.12
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  // Unsigned Q1.30 arithmetic of the exponential
  localparam int          QSHIFT    = 30;
  localparam logic [30:0] Q30_ONE   = 31'd1073741824;
  localparam logic [30:0] Q30_HALF  = 31'd536870912;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  // Widths of the polynomial terms
  localparam int H_W  = 27;
  localparam int U_W  = 27;
  localparam int U2_W = 24;
  localparam int U3_W = 21;
  localparam int Q_W  = 19;

  // floor(x / 3) for x below 2^20 as (x * DIV3_K) >> DIV3_SHIFT
  localparam int          DIV3_SHIFT = 22;
  localparam logic [20:0] DIV3_K     = 21'd1398102;

  // Register stages inside the exponential pipeline
  localparam int EXP_LAT = 8;

  // Configuration register word indexes
  localparam logic REG_ALPHA = 1'b0;

  // Exponential result handed to the scaling stage
  typedef struct packed {
    logic        valid;
    logic [30:0] e;
  } exp_res_t;

  // 2^(-j/8) in Q30
  function automatic logic [30:0] pow2_neg_eighth(input logic [2:0] j);
    logic [30:0] v;
    case (j)
      3'd0:    v = 31'd1073741824;
      3'd1:    v = 31'd984625594;
      3'd2:    v = 31'd902905651;
      3'd3:    v = 31'd827968132;
      3'd4:    v = 31'd759250125;
      3'd5:    v = 31'd696235434;
      3'd6:    v = 31'd638450708;
      3'd7:    v = 31'd585461881;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/elu_exp_pipe.sv -----
`timescale 1ns / 1ps

module elu_exp_pipe
  import elu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  m_valid,
  input  logic [DATA_WIDTH-1:0] m,
  output exp_res_t              res
);

  localparam int PW   = DATA_WIDTH + 31;
  localparam int UPW  = H_W + 30;
  localparam int U2PW = 2 * U_W;
  localparam int U3PW = U2_W + U_W;
  localparam int QPW  = (U3_W - 1) + 21;
  localparam int EPW  = 62;

  typedef struct packed {
    logic [2:0] j;
    logic [4:0] sh;
    logic       big;
  } exp_ctl_t;

  logic [EXP_LAT-1:0] vld_r;

  logic [PW-1:0]    z_prod;
  logic [PW-1:0]    s1_z_r;
  exp_ctl_t         s1_ctl;

  logic [UPW-1:0]   u_prod;
  logic [U_W-1:0]   s2_u_r;
  exp_ctl_t         s2_ctl_r;

  logic [U2PW-1:0]  u2_prod;
  logic [U_W-1:0]   s3_u_r;
  logic [U2_W-1:0]  s3_u2_r;
  exp_ctl_t         s3_ctl_r;

  logic [U3PW-1:0]  u3_prod;
  logic [U_W-1:0]   s4_u_r;
  logic [U2_W-1:0]  s4_u2_r;
  logic [U3_W-1:0]  s4_u3_r;
  exp_ctl_t         s4_ctl_r;

  logic [QPW-1:0]   q_prod;
  logic [30:0]      s5_a_r;
  logic [Q_W-1:0]   s5_q_r;
  exp_ctl_t         s5_ctl_r;

  logic [30:0]      s6_p_r;
  exp_ctl_t         s6_ctl_r;

  logic [EPW-1:0]   e_prod;
  logic [30:0]      s7_e_r;
  exp_ctl_t         s7_ctl_r;

  logic [30:0]      s8_e_r;

  // Exponent of two: |x| * log2(e) in Q30
  assign z_prod = (PW'(m) * PW'(LOG2E_Q30)) >> FRAC_BITS;

  // Split exponent into shift, table index and remainder
  assign s1_ctl.j   = s1_z_r[29:27];
  assign s1_ctl.sh  = s1_z_r[34:30];
  assign s1_ctl.big = |s1_z_r[PW-1:35];

  assign u_prod  = UPW'(s1_z_r[H_W-1:0]) * UPW'(LN2_Q30);
  assign u2_prod = U2PW'(s2_u_r) * U2PW'(s2_u_r);
  assign u3_prod = U3PW'(s3_u2_r) * U3PW'(s3_u_r);
  assign q_prod  = QPW'(s4_u3_r[U3_W-1:1]) * QPW'(DIV3_K);
  assign e_prod  = EPW'(pow2_neg_eighth(s6_ctl_r.j)) * EPW'(s6_p_r);

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[EXP_LAT-2:0], m_valid};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_z_r   <= z_prod;

      s2_u_r   <= u_prod[QSHIFT +: U_W];
      s2_ctl_r <= s1_ctl;

      s3_u_r   <= s2_u_r;
      s3_u2_r  <= u2_prod[QSHIFT +: U2_W];
      s3_ctl_r <= s2_ctl_r;

      s4_u_r   <= s3_u_r;
      s4_u2_r  <= s3_u2_r;
      s4_u3_r  <= u3_prod[QSHIFT +: U3_W];
      s4_ctl_r <= s3_ctl_r;

      s5_a_r   <= Q30_ONE - 31'(s4_u_r) + 31'(s4_u2_r[U2_W-1:1]);
      s5_q_r   <= q_prod[DIV3_SHIFT +: Q_W];
      s5_ctl_r <= s4_ctl_r;

      s6_p_r   <= s5_a_r - 31'(s5_q_r);
      s6_ctl_r <= s5_ctl_r;

      s7_e_r   <= e_prod[QSHIFT +: 31];
      s7_ctl_r <= s6_ctl_r;

      // Drop to zero once the shift clears every bit
      s8_e_r   <= s7_ctl_r.big ? '0 : (s7_e_r >> s7_ctl_r.sh);
    end
  end

  assign res.valid = vld_r[EXP_LAT-1];
  assign res.e     = s8_e_r;

`ifndef SYNTH
  a_poly_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (s6_p_r <= Q30_ONE) && (s6_p_r != '0))
    else $error("polynomial left (0, 1]");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (res.e <= Q30_ONE))
    else $error("exponential above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved while stalled");
`endif

endmodule

// ----- sv/elu_scale.sv -----
`timescale 1ns / 1ps

module elu_scale
  import elu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  exp_res_t              exp_in,
  input  logic [DATA_WIDTH-2:0] alpha,
  output logic                  mag_valid,
  output logic [DATA_WIDTH-1:0] mag
);

  localparam int MPW = DATA_WIDTH + 31;

  logic [30:0]           one_minus_e;
  logic [MPW-1:0]        mag_prod;
  logic                  mag_valid_r;
  logic [DATA_WIDTH-1:0] mag_r;

  // alpha * (1 - e), rounded half up to the sample format
  assign one_minus_e = Q30_ONE - exp_in.e;
  assign mag_prod    = MPW'(alpha) * MPW'(one_minus_e) + MPW'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_valid_r <= 1'b0;
    end else if (en) begin
      mag_valid_r <= exp_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_prod[QSHIFT +: DATA_WIDTH];
    end
  end

  assign mag_valid = mag_valid_r;
  assign mag       = mag_r;

`ifndef SYNTH
  a_mag_follow: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (mag_valid == $past(exp_in.valid)))
    else $error("scaling stage lost a valid bit");
`endif

endmodule

// ----- sv/elu_activation_core.sv -----
`timescale 1ns / 1ps
// ELU activation stream.
// Input channel in_*: one signed fixed-point sample per request in in_tdata,
// with the tensor end marker on in_tlast. Output channel out_*: the ELU of
// the sample in out_tdata, with in_tlast copied to out_tlast.
// Non-negative samples pass unchanged; negative samples give
// alpha * (exp(x) - 1), its magnitude rounded half up.
// Configuration port cfg_*: word 0 holds alpha_gain (unsigned, same fraction
// bits as the sample), reset value 1.0. Write it only while the stream idles.
// Throughput: one request per clock while the receiver does not stall, set by
// the fully pipelined datapath (eight exponential stages, one scaling
// multiplier, input and output registers).
// Reset clears every valid bit, so no result is shown, and restores alpha.
// A stall of the receiver freezes the whole pipeline; in_tready falls in the
// same cycle, and nothing is lost or repeated.
module elu_activation_core
  import elu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     in_tdata,   // [DATA_WIDTH-1:0] sample_in
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     out_tdata,  // [DATA_WIDTH-1:0] sample_out
  output logic                                out_tlast,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int SB_DEPTH = EXP_LAT + 1;
  localparam logic [DATA_WIDTH-2:0] ALPHA_RESET = (DATA_WIDTH-1)'(1) << FRAC_BITS;

  logic                  cfg_wr;
  logic [DATA_WIDTH-2:0] alpha_r;

  logic                  pipe_en;
  logic [DATA_WIDTH-1:0] sample;

  logic                  st0_valid_r;
  logic [DATA_WIDTH-1:0] st0_m_r;
  logic [DATA_WIDTH-1:0] st0_raw_r;
  logic                  st0_last_r;

  logic [DATA_WIDTH-1:0] sb_raw_r  [SB_DEPTH];
  logic                  sb_last_r [SB_DEPTH];

  exp_res_t              exp_res;
  logic                  mag_valid;
  logic [DATA_WIDTH-1:0] mag;
  logic [DATA_WIDTH-1:0] raw_al;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic                  out_last_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_ALPHA)) begin
      alpha_r <= cfg_pwdata[DATA_WIDTH-2:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ALPHA) ? 32'(alpha_r) : '0;

  // Advance the whole pipeline unless a finished result is held
  assign pipe_en   = !out_valid_r || out_tready;
  assign in_tready = pipe_en;
  assign sample    = in_tdata[DATA_WIDTH-1:0];

  // Input stage: magnitude of the sample for the negative side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_valid_r <= 1'b0;
    end else if (pipe_en) begin
      st0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      st0_m_r    <= '0 - sample;
      st0_raw_r  <= sample;
      st0_last_r <= in_tlast;
    end
  end

  // Carry the raw sample and last flag alongside the exponential
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sb_raw_r[0]  <= st0_raw_r;
      sb_last_r[0] <= st0_last_r;
      for (int i = 1; i < SB_DEPTH; i++) begin
        sb_raw_r[i]  <= sb_raw_r[i-1];
        sb_last_r[i] <= sb_last_r[i-1];
      end
    end
  end

  elu_exp_pipe #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .m_valid (st0_valid_r),
    .m       (st0_m_r),
    .res     (exp_res)
  );

  elu_scale #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .exp_in    (exp_res),
    .alpha     (alpha_r),
    .mag_valid (mag_valid),
    .mag       (mag)
  );

  assign raw_al = sb_raw_r[SB_DEPTH-1];

  // Output register: pass non-negative samples, negate the scaled magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_data_r <= raw_al[DATA_WIDTH-1] ? ('0 - mag) : raw_al;
      out_last_r <= sb_last_r[SB_DEPTH-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(st0_valid_r) && $stable(mag_valid) && $stable(out_data_r))
    else $error("pipeline moved while the receiver stalled");

  a_alpha_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_paddr[2] == REG_ALPHA) |=> alpha_r == $past(cfg_pwdata[DATA_WIDTH-2:0]))
    else $error("alpha write not taken");
`endif

endmodule

// ----- bench/elu_activation_core_tb.sv -----
`timescale 1ns / 1ps

module elu_activation_core_tb;
  import elu_pkg::*;

  localparam int SW         = DATA_WIDTH_DEF;
  localparam int FB         = FRAC_BITS_DEF;
  localparam int AW         = SW - 1;
  localparam int ALPHA_IDX  = REG_ALPHA;
  localparam int SPARE_IDX  = 1;
  localparam int ALPHA_RST  = 4096;
  localparam int PIPE_DRAIN = 14;
  localparam int STALL_MAX  = 19;
  localparam int WDOG_LIMIT = 1000;
  localparam int RAND_ITEMS = 1650;
  localparam int PHASES     = 6;

  // Exponential constants in unsigned Q30
  localparam longint unsigned ONE_Q30   = 64'd1 << 30;
  localparam longint unsigned LOG2E_K   = 64'd1549082005;
  localparam longint unsigned LN2_K     = 64'd744261118;
  localparam longint unsigned FRAC_MASK = (64'd1 << 27) - 64'd1;
  localparam longint unsigned EIGHTHS [8] = '{
    64'd1073741824, 64'd984625594, 64'd902905651, 64'd827968132,
    64'd759250125,  64'd696235434, 64'd638450708, 64'd585461881
  };

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          last;
  } elu_item_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [SW-1:0] in_tdata;   // [15:0] sample_in
  logic          in_tlast;
  logic          out_tvalid;
  logic          out_tready;
  logic [SW-1:0] out_tdata;  // [15:0] sample_out
  logic          out_tlast;
  logic          cfg_psel;
  logic          cfg_penable;
  logic          cfg_pwrite;
  logic [2:0]    cfg_paddr;
  logic [31:0]   cfg_pwdata;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  elu_item_t     elu_results_due[$];
  logic [AW-1:0] alpha_model;
  bit            no_idle;
  int            errors;
  int            quiet_cycles;

  elu_activation_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ELU of one sample under the given alpha; exp via 2^-(m*log2e)
  function automatic logic [SW-1:0] elu_of(logic [SW-1:0] x, logic [AW-1:0] alpha);
    longint unsigned m, z, n, j, h, u, u2, u3, p, e, mag;
    if (!x[SW-1])
      return x;
    m   = (64'd1 << SW) - 64'(x);
    z   = (m * LOG2E_K) >> FB;
    n   = z >> 30;
    j   = (z >> 27) & 64'd7;
    h   = z & FRAC_MASK;
    u   = (h * LN2_K) >> 30;
    u2  = (u * u) >> 30;
    u3  = (u2 * u) >> 30;
    p   = ONE_Q30 - u + (u2 >> 1) - (u3 / 64'd6);
    e   = (EIGHTHS[j] * p) >> 30;
    e   = (n >= 64'd40) ? 64'd0 : (e >> n);
    mag = (64'(alpha) * (ONE_Q30 - e) + (64'd1 << 29)) >> 30;
    return SW'((64'd1 << SW) - mag);
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR @%0t: %s got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Send one request, wait for acceptance and log the expected result
  task automatic send_sample(logic [SW-1:0] s, logic last);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    elu_results_due.push_back('{sample: elu_of(s, alpha_model), last: last});
  endtask

  // Hold the stream idle until every result is out and the pipe is empty
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (elu_results_due.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic cfg_write(int idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * idx);
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (idx == ALPHA_IDX)
      alpha_model = value[AW-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_alpha_readback();
    logic [31:0] rd;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= 3'(4 * ALPHA_IDX);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rd = cfg_prdata;
    if (rd !== 32'(alpha_model))
      report_mismatch("alpha_gain readback", rd, 32'(alpha_model));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Zero, positive extremes, negative extremes and the tensor end flag
  task automatic test_sample_extremes();
    logic [SW-1:0] vals [12];
    vals = '{16'h0000, 16'h0001, 16'h7FFF, 16'h1000, 16'hFFFF, 16'h8000,
             16'hF000, 16'hE000, 16'hFFFE, 16'hFF00, 16'hC000, 16'h8001};
    check_alpha_readback();
    foreach (vals[i])
      send_sample(vals[i], logic'(i % 3 == 2));
  endtask

  // Alpha at zero and full scale, bits above the field, unused register index
  task automatic test_alpha_register();
    drain_pipeline();
    cfg_write(ALPHA_IDX, 32'd0);
    check_alpha_readback();
    send_sample(16'hF000, 1'b0);
    send_sample(16'h8000, 1'b1);
    drain_pipeline();
    cfg_write(ALPHA_IDX, 32'd32767);
    check_alpha_readback();
    send_sample(16'h8000, 1'b0);
    send_sample(16'hF000, 1'b1);
    drain_pipeline();
    cfg_write(ALPHA_IDX, 32'hFFFF_FFFF);
    check_alpha_readback();
    send_sample(16'hE000, 1'b0);
    drain_pipeline();
    cfg_write(ALPHA_IDX, 32'h0001_2000);
    check_alpha_readback();
    send_sample(16'hFFF0, 1'b1);
    drain_pipeline();
    cfg_write(SPARE_IDX, 32'h0000_1234);
    check_alpha_readback();
    send_sample(16'hF800, 1'b0);
  endtask

  // Random stream in phases, each under its own alpha
  task automatic test_random_stream();
    logic [AW-1:0] alpha;
    logic [SW-1:0] s;
    int            pick;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       alpha = AW'(ALPHA_RST);
        1:       alpha = '1;
        2:       alpha = '0;
        3:       alpha = AW'(1);
        default: alpha = AW'($urandom);
      endcase
      drain_pipeline();
      cfg_write(ALPHA_IDX, 32'(alpha) | ($urandom & 32'hFFFF_8000));
      check_alpha_readback();
      for (int k = 0; k < RAND_ITEMS / PHASES; k++) begin
        if ($urandom_range(0, 39) == 0)
          no_idle = ~no_idle;
        pick = $urandom_range(0, 3);
        case (pick)
          0, 1:    s = SW'($urandom);
          2:       s = SW'(-$urandom_range(1, 64));
          default: s = SW'(-$urandom_range(1, 16384));
        endcase
        send_sample(s, logic'($urandom_range(0, 7) == 0));
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random back-pressure, compare each result with the oldest due
  initial begin
    elu_item_t want;
    int        stall;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (elu_results_due.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_tdata), 32'h0);
      end else begin
        want = elu_results_due.pop_front();
        if (out_tdata !== want.sample)
          report_mismatch("sample_out", 32'(out_tdata), 32'(want.sample));
        if (out_tlast !== want.last)
          report_mismatch("last_out", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  // Watchdog: end the run if no request moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("elu_activation_core: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    alpha_model  = AW'(ALPHA_RST);
    no_idle      = 1'b0;
    errors       = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sample_extremes();
    test_alpha_register();
    test_random_stream();

    drain_pipeline();
    if (errors == 0 && elu_results_due.size() == 0) begin
      $display("elu_activation_core: match");
    end else begin
      $display("elu_activation_core: mismatch");
    end
    $finish;
  end

endmodule
